[rtl/ect_pkg.sv]
// Shared types, calendar constants and reciprocal constants for the epoch / civil time converter.
// Used by every module of the block; depends on nothing else.
package ect_pkg;

  localparam int unsigned NSTG    = 11;  // pipeline depth, input register to output register
  localparam int unsigned REV_STG = 4;   // stages the civil-to-seconds datapath really needs
  localparam int unsigned NDLY    = NSTG - REV_STG;

  typedef enum logic {
    KIND_TO_CIVIL = 1'b0,
    KIND_TO_EPOCH = 1'b1
  } kind_t;

  typedef struct packed {
    logic [NSTG-1:0] en;  // stage i loads from stage i-1 in this cycle
  } pipe_ctl_t;

  localparam logic [37:0] MAX_EPOCH      = 38'd253402300799;
  localparam logic [13:0] YEAR_MIN       = 14'd1970;
  localparam logic [13:0] YEAR_MAX       = 14'd9999;
  localparam logic [3:0]  MONTH_MAX      = 4'd12;
  localparam logic [21:0] DAY_SHIFT      = 22'd719468;
  localparam logic [17:0] DAYS_PER_ERA   = 18'd146097;
  localparam logic [17:0] DOE_LAST       = 18'd146096;
  localparam logic [9:0]  DAY_SEC_ODD    = 10'd675;  // 86400 with its factor of 128 removed
  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
  localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
  localparam logic [8:0]  YEARS_PER_ERA  = 9'd400;
  localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;
  localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;
  localparam logic [8:0]  LEAP_BIAS      = 9'd477;
  localparam logic [10:0] DAYS_FOUR_YRS  = 11'd1460;
  localparam logic [15:0] DAYS_CENTURY   = 16'd36524;
  localparam logic [7:0]  MP_DIVISOR     = 8'd153;
  localparam logic [6:0]  CENTURY        = 7'd100;

  // Rounded-up reciprocals: floor(x / d) == (x * M) >> K for every x below 2**(K - clog2(d)).
  localparam int unsigned K_675   = 41;
  localparam int unsigned K_ERA   = 40;
  localparam int unsigned K_WEEK  = 25;
  localparam int unsigned K_HOUR  = 29;
  localparam int unsigned K_1460  = 29;
  localparam int unsigned K_CENT  = 34;
  localparam int unsigned K_MIN   = 18;
  localparam int unsigned K_YEAR  = 27;
  localparam int unsigned K_YOE   = 16;
  localparam int unsigned K_YIN   = 21;
  localparam int unsigned K_MP    = 19;

  localparam logic [63:0] M_675  = ((64'd1 << K_675) + 64'(DAY_SEC_ODD) - 64'd1)
                                   / 64'(DAY_SEC_ODD);
  localparam logic [63:0] M_ERA  = ((64'd1 << K_ERA) + 64'(DAYS_PER_ERA) - 64'd1)
                                   / 64'(DAYS_PER_ERA);
  localparam logic [63:0] M_WEEK = ((64'd1 << K_WEEK) + 64'(DAYS_PER_WEEK) - 64'd1)
                                   / 64'(DAYS_PER_WEEK);
  localparam logic [63:0] M_HOUR = ((64'd1 << K_HOUR) + 64'(SECS_PER_HOUR) - 64'd1)
                                   / 64'(SECS_PER_HOUR);
  localparam logic [63:0] M_1460 = ((64'd1 << K_1460) + 64'(DAYS_FOUR_YRS) - 64'd1)
                                   / 64'(DAYS_FOUR_YRS);
  localparam logic [63:0] M_CENT = ((64'd1 << K_CENT) + 64'(DAYS_CENTURY) - 64'd1)
                                   / 64'(DAYS_CENTURY);
  localparam logic [63:0] M_MIN  = ((64'd1 << K_MIN) + 64'(SECS_PER_MIN) - 64'd1)
                                   / 64'(SECS_PER_MIN);
  localparam logic [63:0] M_YEAR = ((64'd1 << K_YEAR) + 64'(DAYS_PER_YEAR) - 64'd1)
                                   / 64'(DAYS_PER_YEAR);
  localparam logic [63:0] M_YOE  = ((64'd1 << K_YOE) + 64'(CENTURY) - 64'd1)
                                   / 64'(CENTURY);
  localparam logic [63:0] M_YIN  = ((64'd1 << K_YIN) + 64'(CENTURY) - 64'd1)
                                   / 64'(CENTURY);
  localparam logic [63:0] M_MP   = ((64'd1 << K_MP) + 64'(MP_DIVISOR) - 64'd1)
                                   / 64'(MP_DIVISOR);

  // Day of the March-based year on which month index mp starts: (153 * mp + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] off;
    unique case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  // Days in a common year before the first of the given month; month zero counts as January.
  function automatic logic [8:0] days_before_month(input logic [3:0] mo);
    logic [8:0] dbm;
    unique case (mo)
      4'd2:    dbm = 9'd31;
      4'd3:    dbm = 9'd59;
      4'd4:    dbm = 9'd90;
      4'd5:    dbm = 9'd120;
      4'd6:    dbm = 9'd151;
      4'd7:    dbm = 9'd181;
      4'd8:    dbm = 9'd212;
      4'd9:    dbm = 9'd243;
      4'd10:   dbm = 9'd273;
      4'd11:   dbm = 9'd304;
      4'd12:   dbm = 9'd334;
      default: dbm = 9'd0;
    endcase
    return dbm;
  endfunction

endpackage

[rtl/ect_pipe_ctrl.sv]
// Valid bits, selector bits and per-stage load enables of the converter pipeline.
// Depends on ect_pkg.
module ect_pipe_ctrl
  import ect_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_valid,
  input  kind_t     s_kind,
  input  logic      m_ready,
  output pipe_ctl_t ctl,
  output logic      s_ready,
  output logic      m_valid,
  output kind_t     m_kind
);

  logic [NSTG-1:0] vld;
  kind_t           knd [NSTG];

  // A stage may load when it or any stage after it holds a bubble, or the output drains.
  for (genvar g = 0; g < NSTG; g++) begin : g_en
    assign ctl.en[g] = m_ready | ~(&vld[NSTG-1:g]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctl.en[0]) begin
        vld[0] <= s_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (ctl.en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      knd[0] <= s_kind;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (ctl.en[i]) begin
        knd[i] <= knd[i-1];
      end
    end
  end

  assign s_ready = ctl.en[0];
  assign m_valid = vld[NSTG-1];
  assign m_kind  = knd[NSTG-1];

endmodule

[rtl/ect_to_civil.sv]
// Seconds-to-civil datapath: eleven register stages built around constant reciprocal products.
// Depends on ect_pkg; load enables come from ect_pipe_ctrl.
module ect_to_civil
  import ect_pkg::*;
(
  input  logic        clk,
  input  pipe_ctl_t   ctl,
  input  logic [37:0] epoch_seconds,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [2:0]  weekday
);

  // Stage 1: clamp, split off the factor of 128 and start the divide by 675.
  logic [37:0] secs_sat;
  logic [30:0] st1_x;
  logic [6:0]  st1_lo;
  logic [62:0] st1_prod;

  assign secs_sat = (epoch_seconds > MAX_EPOCH) ? MAX_EPOCH : epoch_seconds;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      st1_x    <= secs_sat[37:7];
      st1_lo   <= secs_sat[6:0];
      st1_prod <= 63'(secs_sat[37:7]) * 63'(M_675);
    end
  end

  // Stage 2: day count and second of day.
  logic [21:0] days_q;
  logic [30:0] days_back;
  logic [9:0]  sod_hi;
  logic [21:0] st2_z;
  logic [21:0] st2_wdx;
  logic [16:0] st2_sod;

  assign days_q    = st1_prod[K_675 +: 22];
  assign days_back = 31'(days_q) * 31'(DAY_SEC_ODD);
  assign sod_hi    = 10'(st1_x - days_back);

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      st2_z   <= days_q + DAY_SHIFT;
      st2_wdx <= days_q + 22'(EPOCH_WEEKDAY);
      st2_sod <= {sod_hi, st1_lo};
    end
  end

  // Stage 3: reciprocal products for era, weekday and hour.
  logic [21:0] st3_z;
  logic [21:0] st3_wdx;
  logic [16:0] st3_sod;
  logic [44:0] st3_pera;
  logic [44:0] st3_pwd;
  logic [34:0] st3_phr;

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      st3_z    <= st2_z;
      st3_wdx  <= st2_wdx;
      st3_sod  <= st2_sod;
      st3_pera <= 45'(st2_z) * 45'(M_ERA);
      st3_pwd  <= 45'(st2_wdx) * 45'(M_WEEK);
      st3_phr  <= 35'(st2_sod) * 35'(M_HOUR);
    end
  end

  // Stage 4: remainders give day of era, weekday and second of hour.
  logic [4:0]  era_q;
  logic [21:0] era_back;
  logic [19:0] wd_q;
  logic [21:0] wd_back;
  logic [5:0]  hr_q;
  logic [16:0] hr_back;
  logic [4:0]  st4_era;
  logic [17:0] st4_doe;
  logic [2:0]  st4_wd;
  logic [4:0]  st4_hour;
  logic [11:0] st4_r3600;

  assign era_q    = st3_pera[K_ERA +: 5];
  assign era_back = 22'(era_q) * 22'(DAYS_PER_ERA);
  assign wd_q     = st3_pwd[K_WEEK +: 20];
  assign wd_back  = 22'(wd_q) * 22'(DAYS_PER_WEEK);
  assign hr_q     = st3_phr[K_HOUR +: 6];
  assign hr_back  = 17'(hr_q) * 17'(SECS_PER_HOUR);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      st4_era   <= era_q;
      st4_doe   <= 18'(st3_z - era_back);
      st4_wd    <= 3'(st3_wdx - wd_back);
      st4_hour  <= hr_q[4:0];
      st4_r3600 <= 12'(st3_sod - hr_back);
    end
  end

  // Stage 5: products for the leap-cycle corrections and the minute.
  logic [4:0]  st5_era;
  logic [17:0] st5_doe;
  logic [2:0]  st5_wd;
  logic [4:0]  st5_hour;
  logic [11:0] st5_r3600;
  logic [36:0] st5_p1460;
  logic [36:0] st5_pcent;
  logic [24:0] st5_pmin;

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      st5_era   <= st4_era;
      st5_doe   <= st4_doe;
      st5_wd    <= st4_wd;
      st5_hour  <= st4_hour;
      st5_r3600 <= st4_r3600;
      st5_p1460 <= 37'(st4_doe) * 37'(M_1460);
      st5_pcent <= 37'(st4_doe) * 37'(M_CENT);
      st5_pmin  <= 25'(st4_r3600) * 25'(M_MIN);
    end
  end

  // Stage 6: leap-corrected day of era, minute and second.
  logic [7:0]  q1460;
  logic [2:0]  qcent;
  logic        qlast;
  logic [5:0]  min_q;
  logic [11:0] min_back;
  logic [17:0] st6_t;
  logic [17:0] st6_doe;
  logic [4:0]  st6_era;
  logic [2:0]  st6_wd;
  logic [4:0]  st6_hour;
  logic [5:0]  st6_min;
  logic [5:0]  st6_sec;

  assign q1460    = st5_p1460[K_1460 +: 8];
  assign qcent    = st5_pcent[K_CENT +: 3];
  assign qlast    = (st5_doe == DOE_LAST);
  assign min_q    = st5_pmin[K_MIN +: 6];
  assign min_back = 12'(min_q) * 12'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      st6_t    <= st5_doe - 18'(q1460) + 18'(qcent) - 18'(qlast);
      st6_doe  <= st5_doe;
      st6_era  <= st5_era;
      st6_wd   <= st5_wd;
      st6_hour <= st5_hour;
      st6_min  <= min_q;
      st6_sec  <= 6'(st5_r3600 - min_back);
    end
  end

  // Stage 7: start the divide by 365 for the year of era.
  logic [36:0] st7_pyoe;
  logic [17:0] st7_doe;
  logic [4:0]  st7_era;
  logic [2:0]  st7_wd;
  logic [4:0]  st7_hour;
  logic [5:0]  st7_min;
  logic [5:0]  st7_sec;

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      st7_pyoe <= 37'(st6_t) * 37'(M_YEAR);
      st7_doe  <= st6_doe;
      st7_era  <= st6_era;
      st7_wd   <= st6_wd;
      st7_hour <= st6_hour;
      st7_min  <= st6_min;
      st7_sec  <= st6_sec;
    end
  end

  // Stage 8: year of era, its days and its century count.
  logic [8:0]  yoe;
  logic [8:0]  st8_yoe;
  logic [17:0] st8_p365;
  logic [18:0] st8_pcent;
  logic [17:0] st8_doe;
  logic [4:0]  st8_era;
  logic [2:0]  st8_wd;
  logic [4:0]  st8_hour;
  logic [5:0]  st8_min;
  logic [5:0]  st8_sec;

  assign yoe = st7_pyoe[K_YEAR +: 9];

  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      st8_yoe   <= yoe;
      st8_p365  <= 18'(yoe) * 18'(DAYS_PER_YEAR);
      st8_pcent <= 19'(yoe) * 19'(M_YOE);
      st8_doe   <= st7_doe;
      st8_era   <= st7_era;
      st8_wd    <= st7_wd;
      st8_hour  <= st7_hour;
      st8_min   <= st7_min;
      st8_sec   <= st7_sec;
    end
  end

  // Stage 9: day of the March-based year and the year itself.
  logic [1:0]  yoe_cent;
  logic [17:0] yr_start;
  logic [8:0]  st9_doy;
  logic [13:0] st9_y;
  logic [2:0]  st9_wd;
  logic [4:0]  st9_hour;
  logic [5:0]  st9_min;
  logic [5:0]  st9_sec;

  assign yoe_cent = st8_pcent[K_YOE +: 2];
  assign yr_start = st8_p365 + 18'(st8_yoe[8:2]) - 18'(yoe_cent);

  always_ff @(posedge clk) begin
    if (ctl.en[8]) begin
      st9_doy  <= 9'(st8_doe - yr_start);
      st9_y    <= 14'(st8_yoe) + 14'(st8_era) * 14'(YEARS_PER_ERA);
      st9_wd   <= st8_wd;
      st9_hour <= st8_hour;
      st9_min  <= st8_min;
      st9_sec  <= st8_sec;
    end
  end

  // Stage 10: month index product, (5 * doy + 2) / 153.
  logic [10:0] mp_num;
  logic [22:0] st10_pmp;
  logic [8:0]  st10_doy;
  logic [13:0] st10_y;
  logic [2:0]  st10_wd;
  logic [4:0]  st10_hour;
  logic [5:0]  st10_min;
  logic [5:0]  st10_sec;

  assign mp_num = {st9_doy, 2'b00} + 11'(st9_doy) + 11'd2;

  always_ff @(posedge clk) begin
    if (ctl.en[9]) begin
      st10_pmp  <= 23'(mp_num) * 23'(M_MP);
      st10_doy  <= st9_doy;
      st10_y    <= st9_y;
      st10_wd   <= st9_wd;
      st10_hour <= st9_hour;
      st10_min  <= st9_min;
      st10_sec  <= st9_sec;
    end
  end

  // Stage 11: calendar month and day; January and February belong to the next year.
  logic [3:0] mp;
  logic [3:0] mo;
  logic [8:0] dom;

  assign mp  = st10_pmp[K_MP +: 4];
  assign mo  = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
  assign dom = st10_doy - month_start(mp) + 9'd1;

  always_ff @(posedge clk) begin
    if (ctl.en[10]) begin
      year    <= st10_y + 14'(mo <= 4'd2);
      month   <= mo;
      day     <= dom[4:0];
      hour    <= st10_hour;
      minute  <= st10_min;
      second  <= st10_sec;
      weekday <= st10_wd;
    end
  end

endmodule

[rtl/ect_to_epoch.sv]
// Civil-to-seconds datapath: four working stages, then a delay line to the common pipeline depth.
// Depends on ect_pkg; load enables come from ect_pipe_ctrl.
module ect_to_epoch
  import ect_pkg::*;
(
  input  logic        clk,
  input  pipe_ctl_t   ctl,
  input  logic [13:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic [4:0]  hour_in,
  input  logic [5:0]  minute_in,
  input  logic [5:0]  second_in,
  output logic [37:0] epoch_seconds
);

  // Stage 1: clamp year and month, start the century divides of year and year - 1.
  logic [13:0] yr_c;
  logic [13:0] py_c;
  logic [3:0]  mo_c;
  logic [13:0] rt1_yr;
  logic [13:0] rt1_py;
  logic [3:0]  rt1_mo;
  logic [4:0]  rt1_day;
  logic [4:0]  rt1_hour;
  logic [5:0]  rt1_min;
  logic [5:0]  rt1_sec;
  logic [28:0] rt1_pyr;
  logic [28:0] rt1_ppy;

  assign yr_c = (year_in < YEAR_MIN) ? YEAR_MIN :
                (year_in > YEAR_MAX) ? YEAR_MAX : year_in;
  assign py_c = yr_c - 14'd1;
  assign mo_c = (month_in > MONTH_MAX) ? MONTH_MAX : month_in;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      rt1_yr   <= yr_c;
      rt1_py   <= py_c;
      rt1_mo   <= mo_c;
      rt1_day  <= day_in;
      rt1_hour <= hour_in;
      rt1_min  <= minute_in;
      rt1_sec  <= second_in;
      rt1_pyr  <= 29'(yr_c) * 29'(M_YIN);
      rt1_ppy  <= 29'(py_c) * 29'(M_YIN);
    end
  end

  // Stage 2: day count and time of day. A year ends a century exactly when its century
  // count differs from that of the year before, and likewise for four centuries.
  logic [6:0]  y_cent;
  logic [6:0]  p_cent;
  logic        leap;
  logic [21:0] year_days;
  logic [23:0] days_sum;
  logic [16:0] tod;
  logic signed [23:0] rt2_days;
  logic [16:0] rt2_tod;

  assign y_cent    = rt1_pyr[K_YIN +: 7];
  assign p_cent    = rt1_ppy[K_YIN +: 7];
  assign leap      = ((rt1_yr[1:0] == 2'b00) && (y_cent == p_cent)) ||
                     (y_cent[6:2] != p_cent[6:2]);
  assign year_days = 22'(rt1_yr - YEAR_MIN) * 22'(DAYS_PER_YEAR);
  assign days_sum  = 24'(year_days) + 24'(rt1_py[13:2]) - 24'(p_cent) + 24'(p_cent[6:2])
                   - 24'(LEAP_BIAS) + 24'(days_before_month(rt1_mo)) + 24'(rt1_day)
                   - 24'd1 + 24'((rt1_mo > 4'd2) && leap);
  assign tod       = 17'(rt1_hour) * 17'(SECS_PER_HOUR) + 17'(rt1_min) * 17'(SECS_PER_MIN)
                   + 17'(rt1_sec);

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      rt2_days <= signed'(days_sum);
      rt2_tod  <= tod;
    end
  end

  // Stage 3: days to seconds. The day count can be minus one, so the product is signed.
  logic signed [40:0] rt3_pd;
  logic [16:0]        rt3_tod;

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      rt3_pd  <= 41'(rt2_days) * signed'(41'(SECS_PER_DAY));
      rt3_tod <= rt2_tod;
    end
  end

  // Stage 4: add the time of day and saturate to the supported range.
  logic signed [40:0] total;
  logic [37:0]        rt4_epoch;

  assign total = rt3_pd + signed'({24'd0, rt3_tod});

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      if (total[40]) begin
        rt4_epoch <= '0;
      end else if (total[39:0] > 40'(MAX_EPOCH)) begin
        rt4_epoch <= MAX_EPOCH;
      end else begin
        rt4_epoch <= total[37:0];
      end
    end
  end

  // Delay line keeps results in step with the civil datapath.
  logic [37:0] dly [NDLY];

  always_ff @(posedge clk) begin
    if (ctl.en[REV_STG]) begin
      dly[0] <= rt4_epoch;
    end
    for (int i = 1; i < NDLY; i++) begin
      if (ctl.en[REV_STG+i]) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  assign epoch_seconds = dly[NDLY-1];

endmodule

[rtl/epoch_civil_time_converter.sv]
// Top level of the epoch / civil time converter: stream ports, pipeline control and both datapaths.
// Depends on ect_pkg, ect_pipe_ctrl, ect_to_civil and ect_to_epoch.
//
//   Port group  Dir  Width                  Contents
//   s_axis      in   tdata 80, tuser 1      request beat: epoch seconds or civil time, kind
//   m_axis      out  tdata 88               result beat: epoch seconds or civil time, weekday
//
// One beat per clock in sustained flow while the output is not back-pressured; every beat passes
// 11 register stages before it is offered on the output.
// Depth is set by the seconds-to-civil chain of constant reciprocal divides.
// Reset clears only the stage valid bits; data registers keep whatever they held.
// Back-pressure fills bubbles first, so input stays ready until all 11 stages hold a beat.
module epoch_civil_time_converter
  import ect_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [37:0] epoch_seconds_in, [51:38] year_in, [55:52] month_in, [60:56] day_in,
  // [65:61] hour_in, [71:66] minute_in, [77:72] second_in, [79:78] zero
  input  logic [79:0] s_axis_tdata,
  // [0] kind
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [37:0] epoch_seconds_out, [51:38] year_out, [55:52] month_out, [60:56] day_out,
  // [65:61] hour_out, [71:66] minute_out, [77:72] second_out, [80:78] weekday_out, [87:81] zero
  output logic [87:0] m_axis_tdata
);

  pipe_ctl_t   ctl;
  kind_t       out_kind;
  logic        out_is_epoch;
  logic [37:0] epoch_res;
  logic [13:0] year_res;
  logic [3:0]  month_res;
  logic [4:0]  day_res;
  logic [4:0]  hour_res;
  logic [5:0]  minute_res;
  logic [5:0]  second_res;
  logic [2:0]  weekday_res;

  ect_pipe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_kind  (kind_t'(s_axis_tuser[0])),
    .m_ready (m_axis_tready),
    .ctl     (ctl),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_kind  (out_kind)
  );

  ect_to_civil u_civil (
    .clk           (clk),
    .ctl           (ctl),
    .epoch_seconds (s_axis_tdata[37:0]),
    .year          (year_res),
    .month         (month_res),
    .day           (day_res),
    .hour          (hour_res),
    .minute        (minute_res),
    .second        (second_res),
    .weekday       (weekday_res)
  );

  ect_to_epoch u_epoch (
    .clk           (clk),
    .ctl           (ctl),
    .year_in       (s_axis_tdata[51:38]),
    .month_in      (s_axis_tdata[55:52]),
    .day_in        (s_axis_tdata[60:56]),
    .hour_in       (s_axis_tdata[65:61]),
    .minute_in     (s_axis_tdata[71:66]),
    .second_in     (s_axis_tdata[77:72]),
    .epoch_seconds (epoch_res)
  );

  assign out_is_epoch = (out_kind == KIND_TO_EPOCH);

  // Only the fields of the requested direction are driven; the others read as zero.
  assign m_axis_tdata = out_is_epoch ? {50'd0, epoch_res} :
                        {7'd0, weekday_res, second_res, minute_res, hour_res,
                         day_res, month_res, year_res, 38'd0};

  // Input back-pressure only ever comes from a stalled, full output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  a_civil_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_is_epoch) |->
      (year_res >= YEAR_MIN) && (year_res <= YEAR_MAX) &&
      (month_res >= 4'd1) && (month_res <= 4'd12) && (day_res >= 5'd1) &&
      (hour_res <= 5'd23) && (minute_res <= 6'd59) && (second_res <= 6'd59) &&
      (weekday_res <= 3'd6))
    else $error("civil result field out of range");

  a_epoch_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_is_epoch) |-> (epoch_res <= MAX_EPOCH))
    else $error("epoch result beyond the supported range");

endmodule
